FILE: rtl/dag_longest_path_core_macros.svh
// Assertion helpers for the longest-path core.
`ifndef DAG_LONGEST_PATH_CORE_MACROS_SVH
`define DAG_LONGEST_PATH_CORE_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define DLP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dlp check failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define DLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dlp check failed");

`endif

FILE: rtl/dlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dlp_pkg;

    localparam int VTX_W  = 6;
    localparam int DIST_W = 24;
    localparam int CNT_W  = 7;

    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_COMPUTE = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_OK    = 2'd0,
        KIND_FULL  = 2'd1,
        KIND_RANGE = 2'd2,
        KIND_ROW   = 2'd3
    } kind_t;

    typedef enum logic [0:0] {
        REG_NUM_VERTICES  = 1'b0,
        REG_SOURCE_VERTEX = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [VTX_W-1:0]  edge_from;
        logic [VTX_W-1:0]  edge_to;
        logic signed [15:0] edge_weight;
    } dlp_in_t;

    typedef struct packed {
        logic [1:0]               kind;
        logic [VTX_W-1:0]         vertex;
        logic                     reachable;
        logic signed [DIST_W-1:0] distance;
        logic                     last;
    } dlp_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROOT,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_POP_WAIT,
        ST_RLX_FIN,
        ST_RLX_U,
        ST_RLX_DU,
        ST_RLX_ERD,
        ST_RLX_ECHK,
        ST_RLX_DCMP,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } dlp_state_t;

endpackage
`default_nettype wire

FILE: rtl/dag_longest_path_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Ports                          | Moves
// ----------+--------------------------------+-------------------------------------
// input     | s_valid s_ready s_data         | command transaction (add/compute/clear)
// result    | m_valid m_ready m_data         | status or distance row transaction
// config    | cfg_valid cfg_ready cfg_index  | register write, always ready
//           | cfg_data                       |
//
// Add, clear and unused commands are done in idle; the next one is taken in the
// cycle that the previous result leaves the output register.
// Compute: a depth-first search over the edge memory records the finishing order;
// relaxation then walks the finished vertices in reverse, scanning the edges of each;
// emission reads one distance row per vertex. The edge memory walk dominates.
// Reset is synchronous, active low; a stalled result port holds emission in place.
module dag_longest_path_core #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256,
    parameter int WEIGHT_BITS  = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire dlp_pkg::dlp_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output dlp_pkg::dlp_out_t      m_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_index,
    input  wire logic [6:0]        cfg_data
);
    import dlp_pkg::*;

    localparam int VIW   = $clog2(MAX_VERTICES);
    localparam int EAW   = $clog2(MAX_EDGES);
    localparam int EC_W  = $clog2(MAX_EDGES + 1);
    localparam int SP_W  = $clog2(MAX_VERTICES + 1);
    localparam int EW    = 2 * VTX_W + WEIGHT_BITS;
    localparam int SW    = VTX_W + EC_W;
    localparam int SUM_W = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 <<< (DIST_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(1 <<< (DIST_W - 1)));

    // Configuration registers
    logic [CNT_W-1:0] num_vertices_reg;
    logic [VTX_W-1:0] source_vertex_reg;

    // Control state
    dlp_state_t state_reg, state_next;
    logic [EC_W-1:0]  edge_cnt_reg, edge_cnt_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [MAX_VERTICES-1:0] reached_reg, reached_next;
    logic [SP_W-1:0]  fin_cnt_reg, fin_cnt_next;
    logic [SP_W-1:0]  k_reg, k_next;
    logic [SP_W-1:0]  sp_reg, sp_next;
    logic [CNT_W-1:0] root_reg, root_next;
    logic [EC_W-1:0]  e_reg, e_next;
    logic [VTX_W-1:0] top_reg, top_next;
    logic [VTX_W-1:0] u_reg, u_next;
    logic [VTX_W-1:0] h_reg, h_next;
    logic signed [DIST_W-1:0] du_reg, du_next;
    logic signed [DIST_W-1:0] c_reg, c_next;
    logic m_valid_reg, m_valid_next;
    dlp_out_t m_data_reg, m_data_next;

    // Memory ports
    logic            e_we, e_re;
    logic [EAW-1:0]  e_waddr, e_raddr;
    logic [EW-1:0]   e_wdata, e_rdata;
    logic            s_we, s_re;
    logic [VIW-1:0]  s_waddr, s_raddr;
    logic [SW-1:0]   s_wdata, s_rdata;
    logic            f_we, f_re;
    logic [VIW-1:0]  f_waddr, f_raddr;
    logic [VTX_W-1:0] f_wdata, f_rdata;
    logic            d_we, d_re;
    logic [VIW-1:0]  d_waddr, d_raddr;
    logic [DIST_W-1:0] d_wdata, d_rdata;

    dlp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .aclk(aclk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .re(e_re), .raddr(e_raddr), .rdata(e_rdata)
    );
    dlp_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stack_ram (
        .aclk(aclk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
    );
    dlp_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_finish_ram (
        .aclk(aclk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .re(f_re), .raddr(f_raddr), .rdata(f_rdata)
    );
    dlp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES)) u_dist_ram (
        .aclk(aclk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .re(d_re), .raddr(d_raddr), .rdata(d_rdata)
    );

    // Effective vertex count, clamped to 1..MAX_VERTICES
    logic [CNT_W-1:0] nv;
    always_comb begin
        if (num_vertices_reg == '0) begin
            nv = CNT_W'(1);
        end else if (num_vertices_reg > CNT_W'(MAX_VERTICES)) begin
            nv = CNT_W'(MAX_VERTICES);
        end else begin
            nv = num_vertices_reg;
        end
    end

    // Edge record fields as read back from memory
    logic [VTX_W-1:0] rd_tail, rd_head;
    logic signed [WEIGHT_BITS-1:0] rd_w;
    assign rd_tail = e_rdata[EW-1 -: VTX_W];
    assign rd_head = e_rdata[WEIGHT_BITS +: VTX_W];
    assign rd_w    = e_rdata[WEIGHT_BITS-1:0];

    logic out_free, s_fire, scan_end, head_ok, push_hit, rlx_hit, u_skip, dist_upd;
    logic root_done, root_seen, emit_last;
    logic signed [31:0] w_ext32;
    logic signed [SUM_W-1:0] sum;
    logic signed [DIST_W-1:0] cand;
    logic from_bad, to_bad;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign scan_end  = e_reg >= edge_cnt_reg;
    assign head_ok   = {1'b0, rd_head} < nv;
    assign push_hit  = (rd_tail == top_reg) && head_ok && !visited_reg[rd_head[VIW-1:0]];
    assign rlx_hit   = (rd_tail == u_reg) && head_ok;
    assign u_skip    = ({1'b0, f_rdata} >= nv) || !reached_reg[f_rdata[VIW-1:0]];
    assign dist_upd  = !reached_reg[h_reg[VIW-1:0]] || (signed'(d_rdata) < c_reg);
    assign root_done = root_reg == nv;
    assign root_seen = visited_reg[root_reg[VIW-1:0]];
    assign emit_last = root_reg == (nv - CNT_W'(1));
    assign w_ext32   = 32'(s_data.edge_weight);
    assign from_bad  = {1'b0, s_data.edge_from} >= nv;
    assign to_bad    = {1'b0, s_data.edge_to} >= nv;

    // Saturating candidate distance
    always_comb begin
        sum = SUM_W'(du_reg) + SUM_W'(rd_w);
        if (sum > SAT_HI) begin
            cand = DIST_W'(SAT_HI);
        end else if (sum < SAT_LO) begin
            cand = DIST_W'(SAT_LO);
        end else begin
            cand = DIST_W'(sum);
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_data.cmd == CMD_COMPUTE) begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (root_done) begin
                    state_next = ST_RLX_FIN;
                end else if (!root_seen) begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                if (!scan_end) begin
                    state_next = ST_SCAN_CHK;
                end else if (sp_reg == SP_W'(1)) begin
                    state_next = ST_ROOT;
                end else begin
                    state_next = ST_POP_WAIT;
                end
            end
            ST_SCAN_CHK:  state_next = ST_SCAN_RD;
            ST_POP_WAIT:  state_next = ST_SCAN_RD;
            ST_RLX_FIN:   state_next = (k_reg == '0) ? ST_EMIT_RD : ST_RLX_U;
            ST_RLX_U:     state_next = u_skip ? ST_RLX_FIN : ST_RLX_DU;
            ST_RLX_DU:    state_next = ST_RLX_ERD;
            ST_RLX_ERD:   state_next = scan_end ? ST_RLX_FIN : ST_RLX_ECHK;
            ST_RLX_ECHK:  state_next = rlx_hit ? ST_RLX_DCMP : ST_RLX_ERD;
            ST_RLX_DCMP:  state_next = ST_RLX_ERD;
            ST_EMIT_RD:   state_next = ST_EMIT_OUT;
            ST_EMIT_OUT: begin
                if (out_free) begin
                    state_next = emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory controls and result register
    always_comb begin
        edge_cnt_next = edge_cnt_reg;
        visited_next  = visited_reg;
        reached_next  = reached_reg;
        fin_cnt_next  = fin_cnt_reg;
        k_next        = k_reg;
        sp_next       = sp_reg;
        root_next     = root_reg;
        e_next        = e_reg;
        top_next      = top_reg;
        u_next        = u_reg;
        h_next        = h_reg;
        du_next       = du_reg;
        c_next        = c_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        e_we = 1'b0; e_re = 1'b0;
        e_waddr = edge_cnt_reg[EAW-1:0];
        e_wdata = {s_data.edge_from, s_data.edge_to, w_ext32[WEIGHT_BITS-1:0]};
        e_raddr = e_reg[EAW-1:0];
        s_we = 1'b0; s_re = 1'b0;
        s_waddr = VIW'(sp_reg - SP_W'(1));
        s_wdata = {top_reg, EC_W'(e_reg + EC_W'(1))};
        s_raddr = VIW'(sp_reg - SP_W'(2));
        f_we = 1'b0; f_re = 1'b0;
        f_waddr = fin_cnt_reg[VIW-1:0];
        f_wdata = top_reg;
        f_raddr = VIW'(k_reg - SP_W'(1));
        d_we = 1'b0; d_re = 1'b0;
        d_waddr = h_reg[VIW-1:0];
        d_wdata = c_reg;
        d_raddr = root_reg[VIW-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    m_data_next = '0;
                    m_data_next.last = 1'b1;
                    case (s_data.cmd)
                        CMD_ADD: begin
                            m_valid_next = 1'b1;
                            if (from_bad || to_bad) begin
                                m_data_next.kind = KIND_RANGE;
                            end else if (edge_cnt_reg == EC_W'(MAX_EDGES)) begin
                                m_data_next.kind = KIND_FULL;
                            end else begin
                                m_data_next.kind = KIND_OK;
                                e_we = 1'b1;
                                edge_cnt_next = edge_cnt_reg + EC_W'(1);
                            end
                        end
                        CMD_CLEAR: begin
                            m_valid_next = 1'b1;
                            m_data_next.kind = KIND_OK;
                            edge_cnt_next = '0;
                        end
                        CMD_COMPUTE: begin
                            visited_next = '0;
                            reached_next = '0;
                            fin_cnt_next = '0;
                            root_next    = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ROOT: begin
                if (root_done) begin
                    // start relaxation: seed the source
                    k_next = fin_cnt_reg;
                    if ({1'b0, source_vertex_reg} < nv) begin
                        reached_next[source_vertex_reg[VIW-1:0]] = 1'b1;
                        d_we    = 1'b1;
                        d_waddr = source_vertex_reg[VIW-1:0];
                        d_wdata = '0;
                    end
                end else if (root_seen) begin
                    root_next = root_reg + CNT_W'(1);
                end else begin
                    visited_next[root_reg[VIW-1:0]] = 1'b1;
                    top_next = root_reg[VTX_W-1:0];
                    sp_next  = SP_W'(1);
                    e_next   = '0;
                end
            end
            ST_SCAN_RD: begin
                if (!scan_end) begin
                    e_re = 1'b1;
                end else begin
                    // pop: record finish, restore the entry below
                    if (fin_cnt_reg < SP_W'(MAX_VERTICES)) begin
                        f_we = 1'b1;
                        fin_cnt_next = fin_cnt_reg + SP_W'(1);
                    end
                    sp_next = sp_reg - SP_W'(1);
                    if (sp_reg == SP_W'(1)) begin
                        root_next = root_reg + CNT_W'(1);
                    end else begin
                        s_re = 1'b1;
                    end
                end
            end
            ST_SCAN_CHK: begin
                e_next = e_reg + EC_W'(1);
                if (push_hit) begin
                    visited_next[rd_head[VIW-1:0]] = 1'b1;
                    if (sp_reg < SP_W'(MAX_VERTICES)) begin
                        s_we     = 1'b1;
                        top_next = rd_head;
                        sp_next  = sp_reg + SP_W'(1);
                        e_next   = '0;
                    end
                end
            end
            ST_POP_WAIT: begin
                top_next = s_rdata[SW-1 -: VTX_W];
                e_next   = s_rdata[EC_W-1:0];
            end
            ST_RLX_FIN: begin
                if (k_reg != '0) begin
                    f_re   = 1'b1;
                    k_next = k_reg - SP_W'(1);
                end else begin
                    root_next = '0;
                end
            end
            ST_RLX_U: begin
                u_next  = f_rdata;
                d_raddr = f_rdata[VIW-1:0];
                d_re    = !u_skip;
            end
            ST_RLX_DU: begin
                du_next = d_rdata;
                e_next  = '0;
            end
            ST_RLX_ERD: begin
                e_re = !scan_end;
            end
            ST_RLX_ECHK: begin
                if (rlx_hit) begin
                    c_next  = cand;
                    h_next  = rd_head;
                    d_raddr = rd_head[VIW-1:0];
                    d_re    = 1'b1;
                end else begin
                    e_next = e_reg + EC_W'(1);
                end
            end
            ST_RLX_DCMP: begin
                e_next = e_reg + EC_W'(1);
                if (dist_upd) begin
                    d_we = 1'b1;
                    reached_next[h_reg[VIW-1:0]] = 1'b1;
                    // self loop: the tail distance moves too
                    if (h_reg == u_reg) begin
                        du_next = c_reg;
                    end
                end
            end
            ST_EMIT_RD: begin
                d_re = 1'b1;
            end
            ST_EMIT_OUT: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_data_next.kind      = KIND_ROW;
                    m_data_next.vertex    = root_reg[VTX_W-1:0];
                    m_data_next.reachable = reached_reg[root_reg[VIW-1:0]];
                    m_data_next.distance  = reached_reg[root_reg[VIW-1:0]] ? d_rdata : '0;
                    m_data_next.last      = emit_last;
                    root_next             = root_reg + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            num_vertices_reg  <= CNT_W'(64);
            source_vertex_reg <= '0;
            edge_cnt_reg      <= '0;
            visited_reg       <= '0;
            reached_reg       <= '0;
            fin_cnt_reg       <= '0;
            k_reg             <= '0;
            sp_reg            <= '0;
            root_reg          <= '0;
            e_reg             <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            edge_cnt_reg <= edge_cnt_next;
            visited_reg  <= visited_next;
            reached_reg  <= reached_next;
            fin_cnt_reg  <= fin_cnt_next;
            k_reg        <= k_next;
            sp_reg       <= sp_next;
            root_reg     <= root_next;
            e_reg        <= e_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_NUM_VERTICES:  num_vertices_reg  <= cfg_data;
                    REG_SOURCE_VERTEX: source_vertex_reg <= cfg_data[VTX_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        top_reg    <= top_next;
        u_reg      <= u_next;
        h_reg      <= h_next;
        du_reg     <= du_next;
        c_reg      <= c_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`include "dag_longest_path_core_macros.svh"

    `DLP_ASSERT_NOW(a_sp_bound, state_reg != ST_IDLE, sp_reg <= SP_W'(MAX_VERTICES))
    `DLP_ASSERT_NOW(a_edge_bound, 1'b1, edge_cnt_reg <= EC_W'(MAX_EDGES))
    `DLP_ASSERT_NOW(a_fin_bound, 1'b1, fin_cnt_reg <= SP_W'(MAX_VERTICES))
    `DLP_ASSERT_NEXT(a_row_loaded, state_reg == ST_EMIT_OUT && out_free,
                     m_valid_reg && m_data_reg.kind == KIND_ROW)

endmodule
`default_nettype wire

FILE: rtl/dlp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module dlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import dlp_pkg::*;

    localparam int  EDGE_SLOTS  = 256;
    localparam int  VTX_SLOTS   = 64;
    localparam int  DRAIN_WAIT  = 20;
    localparam int  LONG_HOLD   = 400;
    localparam int  RAND_TARGET = 50;
    localparam longint CYCLE_LIMIT = 20000000;

    // One line of the directed plan: either a register update or a transaction.
    typedef struct packed {
        logic       is_cfg;
        logic [6:0] nv;
        logic [5:0] src;
        dlp_in_t    txn;
        logic       typed;
        kind_t      kind;
    } plan_row_t;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    dlp_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    dlp_out_t m_data;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic     cfg_index = REG_NUM_VERTICES;
    logic [6:0] cfg_data = '0;

    // Shadow copy of the block's graph state and registers.
    logic [5:0]  edge_tail [EDGE_SLOTS];
    logic [5:0]  edge_head [EDGE_SLOTS];
    int          edge_wt   [EDGE_SLOTS];
    int          edge_cnt;
    logic [6:0]  shadow_nv;
    logic [5:0]  shadow_src;

    dlp_out_t    pending_rows [$];
    int          errors;
    int          results_seen;
    int          computes_run;
    int          rand_items;
    bit          gaps_on;
    bit          calm;
    bit          long_hold;
    longint      cycles;

    dag_longest_path_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("dag_longest_path_core regression: fail");
            $finish;
        end
    end

    function automatic int vertex_span();
        if (shadow_nv == 0) return 1;
        if (shadow_nv > VTX_SLOTS) return VTX_SLOTS;
        return shadow_nv;
    endfunction

    // Append one expectation at the tail of the queue.
    task automatic expect_row(dlp_out_t r);
        pending_rows.insert(pending_rows.size(), r);
    endtask

    // Depth-first finishing order, then longest-path relaxation in reverse.
    task automatic queue_distance_rows();
        int   nv;
        int   sp;
        int   fin_cnt;
        int   u;
        int   h;
        int   e;
        int   cand;
        bit   pushed;
        bit   visited [VTX_SLOTS];
        bit   reached [VTX_SLOTS];
        int   best_len [VTX_SLOTS];
        int   fin     [VTX_SLOTS];
        int   stk_v   [VTX_SLOTS];
        int   stk_e   [VTX_SLOTS];
        dlp_out_t row;
        nv = vertex_span();
        fin_cnt = 0;
        for (int i = 0; i < VTX_SLOTS; i++) begin
            visited[i] = 0;
            reached[i] = 0;
            best_len[i] = 0;
        end
        for (int i = 0; i < nv; i++) begin
            if (!visited[i]) begin
                visited[i] = 1;
                stk_v[0] = i;
                stk_e[0] = 0;
                sp = 1;
                while (sp > 0) begin
                    u = stk_v[sp-1];
                    pushed = 0;
                    for (e = stk_e[sp-1]; e < edge_cnt; e++) begin
                        h = edge_head[e];
                        if (edge_tail[e] == u && h < nv && !visited[h]) begin
                            stk_e[sp-1] = e + 1;
                            visited[h] = 1;
                            if (sp < VTX_SLOTS) begin
                                stk_v[sp] = h;
                                stk_e[sp] = 0;
                                sp++;
                            end
                            pushed = 1;
                            break;
                        end
                    end
                    if (!pushed) begin
                        sp--;
                        if (fin_cnt < VTX_SLOTS) begin
                            fin[fin_cnt] = u;
                            fin_cnt++;
                        end
                    end
                end
            end
        end
        if (shadow_src < nv) begin
            reached[shadow_src] = 1;
            best_len[shadow_src] = 0;
        end
        for (int k = fin_cnt; k > 0; k--) begin
            u = fin[k-1];
            if (u < nv && reached[u]) begin
                for (e = 0; e < edge_cnt; e++) begin
                    h = edge_head[e];
                    if (edge_tail[e] == u && h < nv) begin
                        cand = best_len[u] + edge_wt[e];
                        if (cand > 8388607) cand = 8388607;
                        if (cand < -8388608) cand = -8388608;
                        if (!reached[h] || best_len[h] < cand) begin
                            best_len[h] = cand;
                            reached[h] = 1;
                        end
                    end
                end
            end
        end
        for (int i = 0; i < nv; i++) begin
            row = '0;
            row.kind = KIND_ROW;
            row.vertex = i[5:0];
            row.reachable = reached[i];
            row.distance = reached[i] ? best_len[i][23:0] : '0;
            row.last = (i + 1 == nv);
            expect_row(row);
        end
        computes_run++;
    endtask

    task automatic predict(dlp_in_t txn);
        dlp_out_t st;
        int nv;
        st = '0;
        st.last = 1'b1;
        nv = vertex_span();
        case (cmd_t'(txn.cmd))
            CMD_ADD: begin
                if (txn.edge_from >= nv || txn.edge_to >= nv) begin
                    st.kind = KIND_RANGE;
                end else if (edge_cnt >= EDGE_SLOTS) begin
                    st.kind = KIND_FULL;
                end else begin
                    edge_tail[edge_cnt] = txn.edge_from;
                    edge_head[edge_cnt] = txn.edge_to;
                    edge_wt[edge_cnt] = int'(txn.edge_weight);
                    edge_cnt++;
                    st.kind = KIND_OK;
                end
                expect_row(st);
            end
            CMD_COMPUTE: queue_distance_rows();
            CMD_CLEAR: begin
                edge_cnt = 0;
                st.kind = KIND_OK;
                expect_row(st);
            end
            default: ;
        endcase
    endtask

    // Offer one transaction, optionally after a random gap; predict on acceptance.
    task automatic send_txn(dlp_in_t txn, bit typed, kind_t kind);
        dlp_out_t typed_row;
        if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= txn;
        do @(posedge aclk); while (!s_ready);
        predict(txn);
        if (typed) begin
            typed_row = '0;
            typed_row.kind = kind;
            typed_row.last = 1'b1;
            pending_rows[pending_rows.size() - 1] = typed_row;
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge aclk);
        // an unused command may still be in flight
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [6:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_NUM_VERTICES) shadow_nv = val;
        else shadow_src = val[5:0];
    endtask

    task automatic configure(logic [6:0] nv, logic [5:0] src);
        drain();
        write_reg(REG_NUM_VERTICES, nv);
        write_reg(REG_SOURCE_VERTEX, {1'b0, src});
        cfg_valid <= 1'b0;
    endtask

    function automatic dlp_in_t make_txn(cmd_t c, int f, int t, int w);
        dlp_in_t x;
        x.cmd = c;
        x.edge_from = f[5:0];
        x.edge_to = t[5:0];
        x.edge_weight = w[15:0];
        return x;
    endfunction

    function automatic plan_row_t add_row(int f, int t, int w, kind_t k);
        plan_row_t r;
        r = '0;
        r.txn = make_txn(CMD_ADD, f, t, w);
        r.typed = 1'b1;
        r.kind = k;
        return r;
    endfunction

    function automatic plan_row_t cmd_row(cmd_t c);
        plan_row_t r;
        r = '0;
        r.txn = make_txn(c, 0, 0, 0);
        r.typed = (c == CMD_CLEAR);
        r.kind = KIND_OK;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(int nv, int src);
        plan_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.nv = nv[6:0];
        r.src = src[5:0];
        return r;
    endfunction

    // Result side: random back-pressure plus one long hold-off on request.
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold = 0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Compare every accepted result against the oldest expectation.
    always @(posedge aclk) begin
        dlp_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_rows.size() == 0) begin
                errors++;
                $display("%0t: unexpected result kind=%0d vertex=%0d reach=%0d dist=%0d last=%0d",
                         $time, m_data.kind, m_data.vertex, m_data.reachable,
                         m_data.distance, m_data.last);
            end else begin
                want = pending_rows.pop_front();
                if (m_data.kind !== want.kind || m_data.vertex !== want.vertex ||
                    m_data.reachable !== want.reachable ||
                    m_data.distance !== want.distance || m_data.last !== want.last) begin
                    errors++;
                    $display("%0t: mismatch expected kind=%0d vertex=%0d reach=%0d dist=%0d last=%0d",
                             $time, want.kind, want.vertex, want.reachable,
                             want.distance, want.last);
                    $display("%0t:          actual   kind=%0d vertex=%0d reach=%0d dist=%0d last=%0d",
                             $time, m_data.kind, m_data.vertex, m_data.reachable,
                             m_data.distance, m_data.last);
                end
            end
        end
    end

    initial begin
        plan_row_t plan [21];
        int nv_pick;
        int span;
        int n_add;
        int phase;
        int f;
        int t;
        dlp_in_t txn;
        errors = 0;
        results_seen = 0;
        computes_run = 0;
        rand_items = 0;
        edge_cnt = 0;
        shadow_nv = 7'd64;
        shadow_src = '0;
        gaps_on = 1;
        calm = 0;
        long_hold = 0;
        cycles = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, a cycle, stale edges, out-of-range source, clamped counts.
        plan = '{
            add_row(0, 1, 32767, KIND_OK),
            add_row(1, 2, -32768, KIND_OK),
            add_row(63, 63, 0, KIND_OK),
            add_row(2, 63, 1, KIND_OK),
            add_row(63, 0, 5, KIND_OK),
            cmd_row(CMD_COMPUTE),
            cmd_row(CMD_CLEAR),
            cmd_row(CMD_NONE),
            add_row(0, 5, 100, KIND_OK),
            add_row(5, 3, -7, KIND_OK),
            cmd_row(CMD_COMPUTE),
            cfg_row(4, 0),
            add_row(4, 0, 9, KIND_RANGE),
            add_row(0, 63, -1, KIND_RANGE),
            cmd_row(CMD_COMPUTE),
            cfg_row(4, 63),
            cmd_row(CMD_COMPUTE),
            cfg_row(0, 0),
            cmd_row(CMD_COMPUTE),
            cfg_row(127, 63),
            cmd_row(CMD_COMPUTE)
        };
        foreach (plan[i]) begin
            if (plan[i].is_cfg) configure(plan[i].nv, plan[i].src);
            else send_txn(plan[i].txn, plan[i].typed, plan[i].kind);
        end

        // Fill the edge table, then hit the full and range checks on a full table.
        configure(7'd4, 6'd1);
        while (edge_cnt < EDGE_SLOTS)
            send_txn(make_txn(CMD_ADD, $urandom_range(0, 3), $urandom_range(0, 3),
                              $urandom), 1'b0, KIND_OK);
        send_txn(make_txn(CMD_ADD, 0, 1, 1), 1'b1, KIND_FULL);
        send_txn(make_txn(CMD_ADD, 0, 9, 1), 1'b1, KIND_RANGE);
        send_txn(make_txn(CMD_COMPUTE, 0, 0, 0), 1'b0, KIND_OK);
        send_txn(make_txn(CMD_CLEAR, 0, 0, 0), 1'b1, KIND_OK);

        // Random graphs: configure, load edges, compute.
        phase = 0;
        while (rand_items < RAND_TARGET) begin
            case ($urandom_range(0, 9))
                0: nv_pick = 64;
                1: nv_pick = $urandom_range(0, 127);
                default: nv_pick = $urandom_range(1, 12);
            endcase
            shadow_nv = nv_pick[6:0];
            span = vertex_span();
            configure(nv_pick[6:0], 6'(($urandom_range(0, 7) == 0) ?
                      $urandom_range(0, 63) : $urandom_range(0, span - 1)));
            gaps_on = ($urandom_range(0, 2) != 0);
            calm = (rand_items > RAND_TARGET - 15);
            if (phase == 1) long_hold = 1;
            if ($urandom_range(0, 3) != 0 || edge_cnt > 200) begin
                send_txn(make_txn(CMD_CLEAR, 0, 0, 0), 1'b0, KIND_OK);
                rand_items++;
            end
            n_add = $urandom_range(0, 2 * span);
            if (n_add > 24) n_add = 24;
            for (int k = 0; k < n_add; k++) begin
                if ($urandom_range(0, 7) == 0) begin
                    f = $urandom_range(0, 63);
                    t = $urandom_range(0, 63);
                end else begin
                    f = $urandom_range(0, span - 1);
                    t = $urandom_range(0, span - 1);
                end
                txn = make_txn(CMD_ADD, f, t, $urandom);
                if ($urandom_range(0, 11) == 0) txn.cmd = CMD_NONE;
                else rand_items++;
                send_txn(txn, 1'b0, KIND_OK);
                // hold the sender until everything in flight is back
                if (phase == 4 && k == n_add / 2) drain();
            end
            send_txn(make_txn(CMD_COMPUTE, 0, 0, 0), 1'b0, KIND_OK);
            rand_items++;
            phase++;
        end

        drain();
        repeat (50) @(posedge aclk);
        $display("covered %0d random transactions and %0d computes; %0d results checked",
                 rand_items, computes_run, results_seen);
        $display("left over expectations: %0d, mismatches: %0d",
                 pending_rows.size(), errors);
        if (errors == 0 && pending_rows.size() == 0) begin
            $display("dag_longest_path_core regression: pass");
        end else begin
            $display("dag_longest_path_core regression: fail");
        end
        $finish;
    end
endmodule
